// ===== src/ssefmm_pkg.sv =====
`default_nettype none
package ssefmm_pkg;

    typedef enum logic [1:0] {
        FMT_PACKED_SINGLE = 2'd0,
        FMT_SCALAR_SINGLE = 2'd1,
        FMT_PACKED_DOUBLE = 2'd2,
        FMT_SCALAR_DOUBLE = 2'd3
    } format_t;

    localparam logic ACT_MIN = 1'b0;
    localparam logic ACT_MAX = 1'b1;

    // Input request held in the input register.
    typedef struct packed {
        logic        action;
        logic [1:0]  format;
        logic [63:0] a_low;
        logic [63:0] a_high;
        logic [63:0] b_low;
        logic [63:0] b_high;
    } req_t;

    // Single lane: a wins when ordered and strictly on the chosen side.
    function automatic logic pick_a_single(input logic [31:0] a, input logic [31:0] b,
                                           input logic is_max);
        logic nan_a;
        logic nan_b;
        logic both_zero;
        logic [31:0] ka;
        logic [31:0] kb;
        logic lt;
        logic gt;
        begin
            nan_a = (&a[30:23]) && (|a[22:0]);
            nan_b = (&b[30:23]) && (|b[22:0]);
            both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
            ka = a[31] ? ~a : {1'b1, a[30:0]};
            kb = b[31] ? ~b : {1'b1, b[30:0]};
            lt = ka < kb;
            gt = kb < ka;
            pick_a_single = !nan_a && !nan_b && !both_zero && (is_max ? gt : lt);
        end
    endfunction

    function automatic logic pick_a_double(input logic [63:0] a, input logic [63:0] b,
                                           input logic is_max);
        logic nan_a;
        logic nan_b;
        logic both_zero;
        logic [63:0] ka;
        logic [63:0] kb;
        logic lt;
        logic gt;
        begin
            nan_a = (&a[62:52]) && (|a[51:0]);
            nan_b = (&b[62:52]) && (|b[51:0]);
            both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
            ka = a[63] ? ~a : {1'b1, a[62:0]};
            kb = b[63] ? ~b : {1'b1, b[62:0]};
            lt = ka < kb;
            gt = kb < ka;
            pick_a_double = !nan_a && !nan_b && !both_zero && (is_max ? gt : lt);
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/ssefmm_lanes.sv =====
`default_nettype none
module ssefmm_lanes (
    input  wire ssefmm_pkg::req_t   req,
    output logic [63:0]             result_low,
    output logic [63:0]             result_high
);
    import ssefmm_pkg::*;

    logic [3:0] sel_s;
    logic [1:0] sel_d;

    always_comb
    begin
        sel_s[0] = pick_a_single(req.a_low[31:0],   req.b_low[31:0],   req.action);
        sel_s[1] = pick_a_single(req.a_low[63:32],  req.b_low[63:32],  req.action);
        sel_s[2] = pick_a_single(req.a_high[31:0],  req.b_high[31:0],  req.action);
        sel_s[3] = pick_a_single(req.a_high[63:32], req.b_high[63:32], req.action);
        sel_d[0] = pick_a_double(req.a_low,  req.b_low,  req.action);
        sel_d[1] = pick_a_double(req.a_high, req.b_high, req.action);
    end

    always_comb
    begin
        unique case (format_t'(req.format))
            FMT_PACKED_SINGLE:
            begin
                result_low  = {sel_s[1] ? req.a_low[63:32] : req.b_low[63:32],
                               sel_s[0] ? req.a_low[31:0]  : req.b_low[31:0]};
                result_high = {sel_s[3] ? req.a_high[63:32] : req.b_high[63:32],
                               sel_s[2] ? req.a_high[31:0]  : req.b_high[31:0]};
            end
            FMT_SCALAR_SINGLE:
            begin
                result_low  = {req.a_low[63:32],
                               sel_s[0] ? req.a_low[31:0] : req.b_low[31:0]};
                result_high = req.a_high;
            end
            FMT_PACKED_DOUBLE:
            begin
                result_low  = sel_d[0] ? req.a_low  : req.b_low;
                result_high = sel_d[1] ? req.a_high : req.b_high;
            end
            default:
            begin
                result_low  = sel_d[0] ? req.a_low : req.b_low;
                result_high = req.a_high;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== src/sse_float_min_max.sv =====
// SSE floating-point minimum and maximum over a 128-bit operand pair.
// The input channel (in_valid, in_stall) carries one request: the action
// (minimum or maximum), the format (packed or scalar, single or double)
// and the two operands as 64-bit halves. The output channel (out_valid,
// out_stall) returns the new destination value as two 64-bit halves.
// Each lane yields a when it is strictly below (minimum) or above
// (maximum) b; equal values, signed zeros and NaNs yield b. Scalar forms
// keep the upper bits of a.
// A request passes an input register, one stage of compare and select
// logic and a result register. An accepted request is registered in the
// input register; its result then loads the result register, which
// raises out_valid. One request is taken every cycle while the output
// does not stall; the throughput is set by the single compare stage.
// A stall at the output holds the result register; the input register
// then drains into it only when it empties, and in_stall rises once both
// registers are full, so no request is lost.
// Reset clears both valid flags; payload registers are not reset.
`default_nettype none
module sse_float_min_max (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         action,
    input  wire  [1:0]  format,
    input  wire  [63:0] a_low,
    input  wire  [63:0] a_high,
    input  wire  [63:0] b_low,
    input  wire  [63:0] b_high,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [63:0] result_low,
    output logic [63:0] result_high
);
    import ssefmm_pkg::*;

    req_t        req_reg;
    logic        req_valid_reg;
    logic [63:0] res_low_reg;
    logic [63:0] res_high_reg;
    logic        res_valid_reg;
    logic [63:0] lane_low;
    logic [63:0] lane_high;
    logic        res_load;
    logic        req_load;

    ssefmm_lanes u_lanes (
        .req         (req_reg),
        .result_low  (lane_low),
        .result_high (lane_high)
    );

    // The result register takes a new value when it is empty or being read.
    assign res_load = !res_valid_reg || !out_stall;
    // The input register takes a request when it is empty or moving on.
    assign req_load = !req_valid_reg || res_load;
    assign in_stall = !req_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_load)
            begin
                req_valid_reg <= in_valid;
            end
            if (res_load)
            begin
                res_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_load && in_valid)
        begin
            req_reg <= '{action: action, format: format, a_low: a_low,
                         a_high: a_high, b_low: b_low, b_high: b_high};
        end
        if (res_load && req_valid_reg)
        begin
            res_low_reg  <= lane_low;
            res_high_reg <= lane_high;
        end
    end

    assign out_valid   = res_valid_reg;
    assign result_low  = res_low_reg;
    assign result_high = res_high_reg;
endmodule
`default_nettype wire

// ===== test/tb_sse_float_min_max.sv =====
module tb_sse_float_min_max;
    timeunit 1ns;
    timeprecision 1ps;

    import ssefmm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [1:0]  format;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_low;
    logic [63:0] b_high;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_low;
    logic [63:0] result_high;

    // Each pending entry is the 128-bit destination value that we predict.
    logic [127:0] pending_dest[$];
    int mismatch_count;
    int idle_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    sse_float_min_max uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .format(format),
        .a_low(a_low), .a_high(a_high), .b_low(b_low), .b_high(b_high),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_low(result_low), .result_high(result_high)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A lane value is turned into an unsigned key whose integer order
    // matches the IEEE order of the values; NaNs and a pair of zeros are
    // caught before the keys are compared, because those always give b.
    function automatic logic [63:0] lane_select(input logic [63:0] x, input logic [63:0] y,
                                                input logic want_max, input logic dbl);
        logic [63:0] sign_bit;
        logic [63:0] mag_mask;
        logic [63:0] exp_mask;
        logic [63:0] kx;
        logic [63:0] ky;
        logic        x_nan;
        logic        y_nan;
        logic        a_wins;
        sign_bit = dbl ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        mag_mask = sign_bit - 64'd1;
        exp_mask = dbl ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000;
        x_nan = ((x & exp_mask) == exp_mask) && ((x & mag_mask & ~exp_mask) != 0);
        y_nan = ((y & exp_mask) == exp_mask) && ((y & mag_mask & ~exp_mask) != 0);
        if (x_nan || y_nan || (((x | y) & mag_mask) == 0))
            return y;
        kx = (x & sign_bit) != 0 ? (~x & (sign_bit | mag_mask)) : (x | sign_bit);
        ky = (y & sign_bit) != 0 ? (~y & (sign_bit | mag_mask)) : (y | sign_bit);
        a_wins = want_max ? (ky < kx) : (kx < ky);
        return a_wins ? x : y;
    endfunction

    function automatic logic [127:0] predict_dest(input logic act, input format_t fmt,
                                                  input logic [127:0] a, input logic [127:0] b);
        logic [127:0] r;
        logic         want_max;
        want_max = (act == ACT_MAX);
        r = a;
        case (fmt)
            FMT_PACKED_SINGLE:
                for (int i = 0; i < 4; i++)
                    r[i*32 +: 32] = lane_select({32'd0, a[i*32 +: 32]},
                                                {32'd0, b[i*32 +: 32]}, want_max, 1'b0);
            FMT_SCALAR_SINGLE:
                r[31:0] = lane_select({32'd0, a[31:0]}, {32'd0, b[31:0]}, want_max, 1'b0);
            FMT_PACKED_DOUBLE:
            begin
                r[63:0] = lane_select(a[63:0], b[63:0], want_max, 1'b1);
                r[127:64] = lane_select(a[127:64], b[127:64], want_max, 1'b1);
            end
            default:
                r[63:0] = lane_select(a[63:0], b[63:0], want_max, 1'b1);
        endcase
        return r;
    endfunction

    // Sends one request, with a random gap beforehand at the sender's idle
    // rate, and holds it until the block takes it. Valid stays high after
    // acceptance so that back-to-back requests follow without a gap; the
    // gap loop or the wait for results drops it.
    task automatic send_request(input logic act, input format_t fmt,
                                input logic [127:0] a, input logic [127:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        format <= fmt;
        a_low <= a[63:0];
        a_high <= a[127:64];
        b_low <= b[63:0];
        b_high <= b[127:64];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_dest.push_back(predict_dest(act, fmt, a, b));
    endtask

    // Random single lane, biased towards zeros, infinities, NaNs,
    // denormals and values of similar magnitude so the compares are close.
    function automatic logic [31:0] rand_single();
        case ($urandom_range(7))
            0: return {1'($urandom_range(1)), 31'd0};
            1: return {1'($urandom_range(1)), 8'hFF, 23'd0};
            2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            3: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
            4: return {1'($urandom_range(1)), 8'($urandom_range(125, 129)),
                       23'($urandom_range(3))};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_double();
        case ($urandom_range(7))
            0: return {1'($urandom_range(1)), 63'd0};
            1: return {1'($urandom_range(1)), 11'h7FF, 52'd0};
            2: return {1'($urandom_range(1)), 11'h7FF, 20'($urandom), 32'($urandom) | 32'd1};
            3: return {1'($urandom_range(1)), 11'h000, 20'($urandom), 32'($urandom)};
            4: return {1'($urandom_range(1)), 11'($urandom_range(1021, 1025)), 50'd0,
                       2'($urandom_range(3))};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [127:0] rand_operand(input format_t fmt);
        logic [127:0] v;
        if (fmt == FMT_PACKED_DOUBLE || fmt == FMT_SCALAR_DOUBLE)
            v = {rand_double(), rand_double()};
        else
            v = {rand_single(), rand_single(), rand_single(), rand_single()};
        return v;
    endfunction

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_dest.size() != 0)
            @(posedge clk);
    endtask

    // Signed zeros, infinities, NaNs and the all-ones and all-zero extremes
    // of every field, in every format and both actions; equal values in packed double.
    task automatic test_directed();
        logic [127:0] pos_zero_s;
        logic [127:0] neg_zero_s;
        logic [127:0] qnan_d;
        pos_zero_s = 128'd0;
        neg_zero_s = {4{32'h8000_0000}};
        qnan_d = {2{64'h7FF8_0000_0000_0001}};
        for (int f = 0; f < 4; f++)
        begin
            send_request(ACT_MIN, format_t'(f), pos_zero_s, neg_zero_s);
            send_request(ACT_MAX, format_t'(f), neg_zero_s, pos_zero_s);
            send_request(ACT_MIN, format_t'(f), {128{1'b1}}, 128'd0);
            send_request(ACT_MAX, format_t'(f), 128'd0, {128{1'b1}});
            send_request(ACT_MAX, format_t'(f), qnan_d, {2{64'h3FF0_0000_3F80_0000}});
            send_request(ACT_MIN, format_t'(f), {4{32'hFF80_0000}}, {4{32'h7F80_0000}});
        end
        send_request(ACT_MAX, FMT_PACKED_DOUBLE, {2{64'h4000_0000_0000_0000}},
                     {2{64'h4000_0000_0000_0000}});
    endtask

    task automatic test_random(input int count);
        format_t fmt;
        for (int i = 0; i < count; i++)
        begin
            fmt = format_t'($urandom_range(3));
            if ($urandom_range(9) == 0)
                send_request(1'($urandom_range(1)), fmt, rand_operand(fmt), rand_operand(fmt));
            else
            begin
                // Often related operands: b is a copy of a or another random operand.
                logic [127:0] a;
                logic [127:0] b;
                a = rand_operand(fmt);
                b = ($urandom_range(3) == 0) ? a : rand_operand(fmt);
                send_request(1'($urandom_range(1)), fmt, a, b);
            end
        end
    endtask

    // The sender holds off until nothing is in flight, then continues.
    task automatic test_drained_pause();
        test_random(20);
        wait_for_results();
        test_random(20);
    endtask

    // Result checker; the receiver's stall is redrawn each cycle.
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_dest.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h_%h", result_high, result_low);
                end
                else
                begin
                    want = pending_dest.pop_front();
                    if (want[63:0] !== result_low || want[127:64] !== result_high)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %h_%h, got %h_%h",
                                     want[127:64], want[63:0], result_high, result_low);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // The watchdog counts cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = ACT_MIN;
        format = FMT_PACKED_SINGLE;
        a_low = '0;
        a_high = '0;
        b_low = '0;
        b_high = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        send_idle_pct = 37;
        recv_idle_pct = 54;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(280);
        send_idle_pct = 54;
        recv_idle_pct = 37;
        test_drained_pause();
        test_random(260);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_dest.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
